// ===== sv/ptc_pkg.sv =====
// Shared types and character constants for the PGN token classifier.
package ptc_pkg;

	// Token classes; KIND_NONE marks that no token is open
	typedef enum logic [2:0] {
		KIND_SPACE   = 3'd0,
		KIND_STRING  = 3'd1,
		KIND_INTEGER = 3'd2,
		KIND_PUNCT   = 3'd3,
		KIND_GLYPH   = 3'd4,
		KIND_SYMBOL  = 3'd5,
		KIND_UNKNOWN = 3'd6,
		KIND_NONE    = 3'd7
	} kind_t;

	// Character constants
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	// Character class flags of one byte
	typedef struct packed {
		logic ws;
		logic quote;
		logic digit;
		logic letter;
		logic sym_extra;
		logic punct;
		logic dollar;
	} char_class_t;

	// One classified result
	typedef struct packed {
		logic [7:0] char_out;
		kind_t      token_kind;
		logic       token_start;
		logic       stream_closed;
		logic       unterminated_string;
	} result_t;

endpackage

// ===== sv/ptc_char_decode.sv =====
// Byte decoder: character class flags and the class of a token starting here.
module ptc_char_decode (
	input  logic [7:0]                char_in,
	output ptc_pkg::char_class_t      cls,
	output ptc_pkg::kind_t            start_kind
);
	import ptc_pkg::*;

	// Class flags
	always_comb begin
		cls.ws        = (char_in == 8'h20) || (char_in inside {[8'h09:8'h0D]});
		cls.quote     = (char_in == CH_QUOTE);
		cls.digit     = char_in inside {["0":"9"]};
		cls.letter    = char_in inside {["a":"z"], ["A":"Z"]};
		cls.sym_extra = char_in inside {CH_UNDER, CH_PLUS, CH_HASH, CH_EQUAL,
			CH_COLON, CH_MINUS};
		cls.punct     = char_in inside {CH_DOT, CH_STAR, CH_LBRACK, CH_RBRACK,
			CH_LT, CH_GT};
		cls.dollar    = (char_in == CH_DOLLAR);
	end

	// Priority order of the start class
	always_comb begin
		if (cls.ws)          start_kind = KIND_SPACE;
		else if (cls.quote)  start_kind = KIND_STRING;
		else if (cls.digit)  start_kind = KIND_INTEGER;
		else if (cls.punct)  start_kind = KIND_PUNCT;
		else if (cls.dollar) start_kind = KIND_GLYPH;
		else if (cls.letter) start_kind = KIND_SYMBOL;
		else                 start_kind = KIND_UNKNOWN;
	end

endmodule

// ===== sv/ptc_token_track.sv =====
// Open-token state and the continue/start decision for each byte.
module ptc_token_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            char_in,
	input  logic                  end_of_input,
	input  ptc_pkg::char_class_t  cls,
	input  ptc_pkg::kind_t        start_kind,
	output ptc_pkg::result_t      result
);
	import ptc_pkg::*;

	kind_t open_kind_q;
	logic  string_open_q;
	kind_t open_kind_d;
	logic  string_open_d;
	logic  cont;

	// Does the open token take this byte
	always_comb begin
		case (open_kind_q)
			KIND_SPACE:   cont = cls.ws;
			KIND_STRING:  cont = string_open_q;
			KIND_INTEGER: cont = cls.digit;
			KIND_GLYPH:   cont = cls.digit;
			KIND_SYMBOL:  cont = cls.letter | cls.digit | cls.sym_extra;
			KIND_UNKNOWN: cont = ~cls.ws;
			default:      cont = 1'b0;
		endcase
	end

	// Result and next state
	always_comb begin
		result        = '0;
		open_kind_d   = open_kind_q;
		string_open_d = string_open_q;
		if (end_of_input) begin
			result.token_kind          = KIND_SPACE;
			result.stream_closed       = 1'b1;
			result.unterminated_string = string_open_q;
			open_kind_d                = KIND_NONE;
			string_open_d              = 1'b0;
		end else if (cont) begin
			result.char_out    = char_in;
			result.token_kind  = open_kind_q;
			result.token_start = 1'b0;
			if (open_kind_q == KIND_STRING && cls.quote)
				string_open_d = 1'b0;
		end else begin
			result.char_out    = char_in;
			result.token_kind  = start_kind;
			result.token_start = 1'b1;
			open_kind_d        = start_kind;
			string_open_d      = (start_kind == KIND_STRING);
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_kind_q   <= KIND_NONE;
			string_open_q <= 1'b0;
		end else if (advance) begin
			open_kind_q   <= open_kind_d;
			string_open_q <= string_open_d;
		end
	end

endmodule

// ===== sv/pgn_token_classifier.sv =====
// Result path: an accepted input request passes through the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls; token state updates once per byte.
// Both sides stall independently; the input register keeps taking requests while
// the result register is free or being drained.
// Reset: arst_n clears the valid bits and the token state (no token open, no string open).
module pgn_token_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  logic        s_axis_tlast,   // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] char_out
	output logic [4:0]  m_axis_tuser,   // [2:0] token_kind, [3] token_start,
	                                    // [4] unterminated_string
	output logic        m_axis_tlast    // stream_closed
);
	import ptc_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eoi_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic        advance;
	char_class_t cls;
	kind_t       start_kind;
	result_t     result;

	// Handshake
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tlast;
		end
	end

	ptc_char_decode u_decode (
		.char_in    (char_s1),
		.cls        (cls),
		.start_kind (start_kind)
	);

	ptc_token_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.cls          (cls),
		.start_kind   (start_kind),
		.result       (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.char_out;
	assign m_axis_tuser  = {res_s2.unterminated_string, res_s2.token_start,
		res_s2.token_kind};
	assign m_axis_tlast  = res_s2.stream_closed;

endmodule

// ===== sv/ptc_checker.sv =====
// Port-level checks for the PGN token classifier, bound to the top level.
module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import ptc_pkg::*;

	logic out_acc;
	logic after_close_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Tracks whether the last delivered result closed the stream (reset counts as closed)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_close_q <= 1'b1;
		end else if (out_acc) begin
			after_close_q <= m_axis_tlast;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Close result carries a zero byte, a zero kind field and no start
	a_close_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'd0 &&
		m_axis_tuser[3:0] == 4'd0)
		else $error("close result carries data");

	// Unterminated-string flag only on the close result
	a_unterm_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tlast)
		else $error("unterminated flag outside close");

	// First byte after reset or close starts a token
	a_start_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_axis_tlast && after_close_q |-> m_axis_tuser[3])
		else $error("first byte of stream did not start a token");

	// Punctuation is always a single-byte token
	a_punct_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_axis_tlast && m_axis_tuser[2:0] == KIND_PUNCT |->
		m_axis_tuser[3])
		else $error("punctuation continued");

endmodule

bind pgn_token_classifier ptc_checker u_ptc_checker (.*);

// ===== bench/pgn_token_classifier_test.sv =====
// Self-checking stream testbench for the PGN token classifier.
module pgn_token_classifier_test;
	import ptc_pkg::*;

	// One byte request: a text byte, or an end-of-stream marker
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [4:0] m_axis_tuser;
	logic       m_axis_tlast;

	byte_req_t pending_bytes[$];
	result_t   expected_results[$];

	// Predictor state: class of the open token and quoted-string flag
	kind_t tok_kind = KIND_NONE;
	logic  in_string = 1'b0;

	int queued_items = 0;
	int requests_taken = 0;
	int closes_taken = 0;
	int open_string_closes = 0;
	int results_checked = 0;
	int fail_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int next_hold_at = 400;
	int rx_cycle = 0;

	pgn_token_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Classify one byte against the open token and advance the token state
	function automatic result_t classify_byte(input logic [7:0] c, input logic eoi);
		result_t r;
		logic    goes_on;
		r = '0;
		if (eoi) begin
			r.stream_closed = 1'b1;
			r.unterminated_string = in_string;
			tok_kind = KIND_NONE;
			in_string = 1'b0;
			return r;
		end
		case (tok_kind)
			KIND_SPACE:               goes_on = is_ws(c);
			KIND_STRING:              goes_on = in_string;
			KIND_INTEGER, KIND_GLYPH: goes_on = is_digit(c);
			KIND_SYMBOL: goes_on = is_letter(c) || is_digit(c) ||
				c inside {CH_UNDER, CH_PLUS, CH_HASH, CH_EQUAL, CH_COLON, CH_MINUS};
			KIND_UNKNOWN:             goes_on = !is_ws(c);
			default:                  goes_on = 1'b0;
		endcase
		if (goes_on) begin
			// closing quote ends the string but stays part of it
			if (tok_kind == KIND_STRING && c == CH_QUOTE)
				in_string = 1'b0;
		end else begin
			if (is_ws(c))
				tok_kind = KIND_SPACE;
			else if (c == CH_QUOTE)
				tok_kind = KIND_STRING;
			else if (is_digit(c))
				tok_kind = KIND_INTEGER;
			else if (c inside {CH_DOT, CH_STAR, CH_LBRACK, CH_RBRACK, CH_LT, CH_GT})
				tok_kind = KIND_PUNCT;
			else if (c == CH_DOLLAR)
				tok_kind = KIND_GLYPH;
			else if (is_letter(c))
				tok_kind = KIND_SYMBOL;
			else
				tok_kind = KIND_UNKNOWN;
			in_string = (tok_kind == KIND_STRING);
		end
		r.char_out = c;
		r.token_kind = tok_kind;
		r.token_start = !goes_on;
		return r;
	endfunction

	// Stimulus helpers
	task automatic push_byte(input logic [7:0] c);
		pending_bytes.insert(pending_bytes.size(), byte_req_t'{ch: c, eoi: 1'b0});
		queued_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_eoi(input logic [7:0] c);
		pending_bytes.insert(pending_bytes.size(), byte_req_t'{ch: c, eoi: 1'b1});
		queued_items++;
	endtask

	function automatic logic [7:0] rand_ws();
		logic [7:0] ws_set[6];
		ws_set = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
		return ws_set[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] rand_symbol_char();
		logic [7:0] extra[6];
		extra = '{CH_UNDER, CH_PLUS, CH_HASH, CH_EQUAL, CH_COLON, CH_MINUS};
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range("0", "9"));
			1:       return extra[$urandom_range(0, 5)];
			2:       return 8'($urandom_range("A", "Z"));
			default: return 8'($urandom_range("a", "z"));
		endcase
	endfunction

	// Token-shaped random traffic with some noise and early stream ends
	task automatic push_random_traffic(input int n_items);
		logic [7:0] c;
		logic [7:0] punct_set[6];
		int         len;
		punct_set = '{CH_DOT, CH_STAR, CH_LBRACK, CH_RBRACK, CH_LT, CH_GT};
		while (queued_items < n_items) begin
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					len = $urandom_range(1, 3);
					repeat (len) push_byte(rand_ws());
				end
				3, 4: begin
					push_byte(CH_QUOTE);
					len = $urandom_range(0, 6);
					repeat (len) begin
						do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
						push_byte(c);
					end
					if ($urandom_range(0, 6) != 0)
						push_byte(CH_QUOTE);
				end
				5, 6: begin
					len = $urandom_range(1, 4);
					repeat (len) push_byte(8'($urandom_range("0", "9")));
				end
				7: push_byte(punct_set[$urandom_range(0, 5)]);
				8: begin
					push_byte(CH_DOLLAR);
					len = $urandom_range(0, 3);
					repeat (len) push_byte(8'($urandom_range("0", "9")));
				end
				9, 10, 11, 12: begin
					push_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
					                               : 8'($urandom_range("A", "Z")));
					len = $urandom_range(0, 5);
					repeat (len) push_byte(rand_symbol_char());
				end
				13: push_byte(8'($urandom_range(0, 255)));
				14: begin
					push_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
					                               : 8'($urandom_range(14, 31)));
					len = $urandom_range(0, 4);
					repeat (len) begin
						do c = 8'($urandom_range(0, 255)); while (is_ws(c));
						push_byte(c);
					end
				end
				15: push_eoi(8'($urandom_range(0, 255)));
				default: push_byte(rand_ws());
			endcase
		end
	endtask

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Request sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : byte_sender
		byte_req_t req;
		result_t   r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				r = classify_byte(s_axis_tdata, s_axis_tlast);
				expected_results.insert(expected_results.size(), r);
				requests_taken++;
				if (s_axis_tlast)
					closes_taken++;
				if (r.unterminated_string)
					open_string_closes++;
			end
			// a request stays put until it is taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					req = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= req.ch;
					s_axis_tlast <= req.eoi;
					burst_left--;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result checker with its own stall pattern and occasional long hold-off
	always @(posedge clk or negedge arst_n) begin : result_check
		result_t exp_r;
		logic    ready_next;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no expectation pending (char_out %0h)",
						m_axis_tdata);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tdata !== exp_r.char_out) begin
						$error("char_out: expected %0h, got %0h", exp_r.char_out, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser[2:0] !== exp_r.token_kind) begin
						$error("token_kind: expected %0d, got %0d", exp_r.token_kind,
							m_axis_tuser[2:0]);
						fail_count++;
					end
					if (m_axis_tuser[3] !== exp_r.token_start) begin
						$error("token_start: expected %0b, got %0b", exp_r.token_start,
							m_axis_tuser[3]);
						fail_count++;
					end
					if (m_axis_tlast !== exp_r.stream_closed) begin
						$error("stream_closed: expected %0b, got %0b", exp_r.stream_closed,
							m_axis_tlast);
						fail_count++;
					end
					if (m_axis_tuser[4] !== exp_r.unterminated_string) begin
						$error("unterminated_string: expected %0b, got %0b",
							exp_r.unterminated_string, m_axis_tuser[4]);
						fail_count++;
					end
				end
				results_checked++;
			end
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (results_checked >= next_hold_at) begin
				// long hold-off so the block backs up into its input
				hold_left = 300;
				next_hold_at += 900;
				ready_next = 1'b0;
			end else begin
				case ((rx_cycle / 97) % 4)
					0:       ready_next = 1'b1;
					1:       ready_next = 1'($urandom_range(0, 1));
					2:       ready_next = (rx_cycle % 4 == 0);
					default: ready_next = ($urandom_range(0, 9) != 0);
				endcase
			end
			m_axis_tready <= ready_next;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		// unknown over extreme bytes, then a whitespace run
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h0D);
		push_byte(8'h20);
		// string holding a space, closed, then a quote that opens a new string
		push_text("\"a \"\"");
		// stream end with a string still open, then an end with nothing open
		push_eoi(8'hFF);
		push_eoi(8'h00);
		// integer, punctuation, glyph, symbol with extras, space, integer, punct
		push_text("07[$9Ra+_ 8>");
		push_eoi(8'h5A);
		push_random_traffic(1775);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (8) @(negedge clk);

		$display("Run covered %0d byte requests and %0d stream ends (%0d with an open string).",
			requests_taken, closes_taken, open_string_closes);
		$display("%0d results checked, with long output stalls and random gaps on both sides.",
			results_checked);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Timeout: %0d results still expected", expected_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
